[rtl/xmcrc_pkg.sv]
// Shared types, codes and constants for the XMODEM-CRC packet receiver.
// Depends on nothing; imported by the controller, the datapath and the top level.
package xmcrc_pkg;

    // Default geometry
    localparam int DEF_PAYLOAD_BYTES = 128;
    localparam int DEF_COUNT_BITS    = 16;

    // CRC-16/XMODEM generator polynomial, seed is zero
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Frame lead bytes and menu keys
    localparam logic [7:0] LEAD_SOH     = 8'h01;
    localparam logic [7:0] LEAD_EOT     = 8'h04;
    localparam logic [7:0] KEY_ERASE    = 8'h31;
    localparam logic [7:0] KEY_DOWNLOAD = 8'h32;
    localparam logic [7:0] KEY_REBOOT   = 8'h37;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_ACK   = 3'd0,
        ACT_NAK   = 3'd1,
        ACT_ERASE = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_RESET = 3'd4
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    take_byte;    // latch one received byte
        logic    clear_frame;  // restart byte position and running CRC
        logic    clear_count;  // packet counter to zero
        logic    incr_count;   // advance packet counter
        logic    load_offset;  // register packet_count * payload size
        logic    load_addr;    // first word address, read word zero
        logic    next_word;    // step address and read the next word
        logic    emit;         // load the output register
        action_t emit_action;
        logic    emit_final;
        logic    emit_write;   // output carries address and data
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       len_one;
        logic       len_frame;
        logic [7:0] lead;
        logic       crc_ok;
        logic       last_word;
        logic       out_free;
    } dp_status_t;

    // One byte through the MSB-first CRC-16 shift register
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/xmodem_crc_packet_receiver_top.sv]
// XMODEM-CRC packet receiver with a small command menu. Bytes that do not end
// a frame are taken one per clock cycle. A byte that ends a frame is then judged
// by the controller, and the results follow one per clock cycle while the result
// side takes each transaction at once: a good packet of PAYLOAD_BYTES bytes first
// reads payload word zero and then gives PAYLOAD_BYTES/8 word writes and an ACK,
// paced by the single read port of the payload word memory and the single output
// register. While results are being produced no new byte is taken; the last result
// may still wait in the output register while the following bytes stream in. The
// user must write the base address only while no frame is being judged or drained;
// the block itself does not enforce this.
// Depends on xmcrc_pkg, xmcrc_ctrl and xmcrc_datapath.
module xmodem_crc_packet_receiver_top
    import xmcrc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [31:0] write_address,
    output logic [63:0] write_data,
    output logic        final_of_run
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller
    xmcrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frame_end (frame_end),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    xmcrc_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .write_address (write_address),
        .write_data    (write_data),
        .final_of_run  (final_of_run)
    );

endmodule

[rtl/xmcrc_ctrl.sv]
// Controller state machine of the XMODEM-CRC packet receiver: mode, frame
// judgement and result sequencing. Depends on xmcrc_pkg.
module xmcrc_ctrl
    import xmcrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       frame_end,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ERASE,
        ST_REBOOT,
        ST_NAK,
        ST_ACK_EOT,
        ST_PREP,
        ST_WRITE,
        ST_ACK_PKT
    } state_t;

    state_t state_reg, state_next;
    logic   mode_reg, mode_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cmd             = '0;
        cmd.emit_action = ACT_ACK;
        cmd.take_byte   = take;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && frame_end)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.clear_frame = 1'b1;
                state_next      = ST_IDLE;
                if (!mode_reg) begin
                    if (status.len_one && status.lead == KEY_ERASE) begin
                        state_next = ST_ERASE;
                    end else if (status.len_one && status.lead == KEY_DOWNLOAD) begin
                        state_next      = ST_ERASE;
                        mode_next       = 1'b1;
                        cmd.clear_count = 1'b1;
                    end else if (status.len_one && status.lead == KEY_REBOOT) begin
                        state_next = ST_REBOOT;
                    end
                end else begin
                    if (status.len_frame && status.lead == LEAD_SOH) begin
                        if (status.crc_ok) begin
                            cmd.load_offset = 1'b1;
                            state_next      = ST_PREP;
                        end else begin
                            state_next = ST_NAK;
                        end
                    end else if (status.len_one && status.lead == LEAD_EOT) begin
                        mode_next  = 1'b0;
                        state_next = ST_ACK_EOT;
                    end
                end
            end
            ST_ERASE:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_ERASE;
                    cmd.emit_final  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_REBOOT:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_RESET;
                    cmd.emit_final  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_NAK:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_NAK;
                    cmd.emit_final  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_ACK_EOT:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_ACK;
                    state_next      = ST_REBOOT;
                end
            end
            ST_PREP:
            begin
                cmd.load_addr = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_WRITE;
                    cmd.emit_write  = 1'b1;
                    if (status.last_word)
                        state_next = ST_ACK_PKT;
                    else
                        cmd.next_word = 1'b1;
                end
            end
            ST_ACK_PKT:
            begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_ACK;
                    cmd.emit_final  = 1'b1;
                    cmd.incr_count  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[rtl/xmcrc_datapath.sv]
// Datapath of the XMODEM-CRC packet receiver: byte position, CRC, payload
// word memory, packet counter, write address and output register. Depends on xmcrc_pkg.
module xmcrc_datapath
    import xmcrc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  rx_byte,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [31:0] write_address,
    output logic [63:0] write_data,
    output logic        final_of_run
);

    localparam int FRAME_LEN = PAYLOAD_BYTES + 5;
    localparam int POS_CAP   = FRAME_LEN + 1;
    localparam int POS_W     = $clog2(POS_CAP + 1);
    localparam int WORDS     = PAYLOAD_BYTES / 8;
    localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PROD_W    = COUNT_BITS + $clog2(PAYLOAD_BYTES + 1);

    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(PAYLOAD_BYTES + 3);
    localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(PAYLOAD_BYTES + 4);
    localparam logic [POS_W-1:0] POS_FRAME  = POS_W'(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_SAT    = POS_W'(POS_CAP);

    logic [31:0]           base_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [15:0]           crc_reg;
    logic [7:0]            lead_reg;
    logic [15:0]           rcv_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [55:0]           acc_reg;
    logic [31:0]           offset_reg;
    logic [31:0]           addr_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [63:0]           rd_data_reg;
    logic                  out_valid_reg;
    action_t               action_reg;
    logic [31:0]           out_addr_reg;
    logic [63:0]           out_data_reg;
    logic                  out_final_reg;

    logic [63:0]           mem [WORDS];

    logic [POS_W-1:0]      pidx;
    logic                  in_payload;
    logic [WORD_W-1:0]     wr_word;
    logic                  rd_en;
    logic [WORD_W-1:0]     rd_addr;
    logic [PROD_W-1:0]     offset_next;

    // Payload byte position decode
    assign pidx       = pos_reg - POS_FIRST;
    assign in_payload = (pos_reg >= POS_FIRST) && (pos_reg < POS_CHK_HI);
    assign wr_word    = WORD_W'(pidx >> 3);

    // Word read port select
    assign rd_en   = cmd.load_addr || cmd.next_word;
    assign rd_addr = cmd.load_addr ? '0 : word_reg + WORD_W'(1);

    assign offset_next = PROD_W'(count_reg) * PROD_W'(PAYLOAD_BYTES);

    // Status to controller
    assign status.len_one   = (pos_reg == POS_W'(1));
    assign status.len_frame = (pos_reg == POS_FRAME);
    assign status.lead      = lead_reg;
    assign status.crc_ok    = (crc_reg == rcv_reg);
    assign status.last_word = (word_reg == WORD_W'(WORDS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_we)
            base_reg <= cfg_data;
    end

    // Advance byte position and CRC, track packet count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
        end else begin
            if (cmd.clear_frame) begin
                pos_reg <= '0;
                crc_reg <= CRC_INIT;
            end else if (cmd.take_byte) begin
                if (pos_reg < POS_SAT)
                    pos_reg <= pos_reg + POS_W'(1);
                if (in_payload)
                    crc_reg <= crc16_byte(crc_reg, rx_byte);
            end
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.incr_count)
                count_reg <= count_reg + COUNT_BITS'(1);
        end
    end

    // Capture lead byte, received check and payload lanes
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte) begin
            if (pos_reg == '0)
                lead_reg <= rx_byte;
            if (pos_reg == POS_CHK_HI)
                rcv_reg[15:8] <= rx_byte;
            if (pos_reg == POS_CHK_LO)
                rcv_reg[7:0] <= rx_byte;
            if (in_payload)
                acc_reg <= {rx_byte, acc_reg[55:8]};
        end
    end

    // Payload word memory: write on the eighth byte of a word, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && in_payload && pidx[2:0] == 3'd7)
            mem[wr_word] <= {rx_byte, acc_reg};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Step write address and word index
    always_ff @(posedge clk)
    begin
        if (cmd.load_offset)
            offset_reg <= 32'(offset_next);
        if (cmd.load_addr) begin
            addr_reg <= base_reg + offset_reg;
            word_reg <= '0;
        end else if (cmd.next_word) begin
            addr_reg <= addr_reg + 32'd8;
            word_reg <= word_reg + WORD_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            action_reg    <= cmd.emit_action;
            out_final_reg <= cmd.emit_final;
            out_addr_reg  <= cmd.emit_write ? addr_reg : 32'd0;
            out_data_reg  <= cmd.emit_write ? rd_data_reg : 64'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign final_of_run  = out_final_reg;

endmodule
